// File: hdl/rdcm_pkg.sv
package rdcm_pkg;

	// field widths fixed by the item and register formats
	localparam int COORD_W   = 16;
	localparam int DELTA_W   = 16;
	localparam int IDX_W     = 6;
	localparam int OUT_W     = 19;
	localparam int DIM_W     = 13;
	localparam int CNT_W     = 7;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;

	// interpolation position fraction, factor format, scale shift
	localparam int PFRAC_W   = 16;
	localparam int FACT_W    = 16;
	localparam int MAG_W     = 32;
	localparam int SCALE_SH  = 31;

	// factor = 1.0 + delta; in Q1.15 that is the delta with its top bit flipped
	localparam logic [FACT_W-1:0] ONE_Q15 = 16'h8000;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_MAP  = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CENTER_ROW   = 3'd0,
		CFG_CENTER_COL   = 3'd1,
		CFG_IMAGE_HEIGHT = 3'd2,
		CFG_IMAGE_WIDTH  = 3'd3,
		CFG_TABLE_COUNT  = 3'd4
	} cfg_reg_t;

	// per-item data carried alongside the arithmetic units
	typedef struct packed {
		logic               op;
		logic [IDX_W-1:0]   idx;
		logic [DELTA_W-1:0] delta;
		logic               row_neg;
		logic [COORD_W-1:0] row_mag;
		logic               col_neg;
		logic [COORD_W-1:0] col_mag;
	} item_side_t;

	typedef struct packed {
		item_side_t it;
		logic       in_edge;
	} div_side_t;

endpackage

// File: hdl/rdcm_if.sv
interface rdcm_in_if import rdcm_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               op;
	logic [COORD_W-1:0] coord_row;
	logic [COORD_W-1:0] coord_col;
	logic [IDX_W-1:0]   entry_index;
	logic signed [DELTA_W-1:0] entry_delta;

	modport source (output valid, op, coord_row, coord_col, entry_index, entry_delta,
		input ready);
	modport sink (input valid, op, coord_row, coord_col, entry_index, entry_delta,
		output ready);
endinterface

interface rdcm_out_if import rdcm_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] src_row;
	logic signed [OUT_W-1:0] src_col;
	logic                    visible;
	logic                    mapped;

	modport source (output valid, src_row, src_col, visible, mapped, input ready);
	modport sink (input valid, src_row, src_col, visible, mapped, output ready);
endinterface

// File: hdl/rdcm_isqrt_pipe.sv
// Integer square root, one root bit per stage.
module rdcm_isqrt_pipe #(
	parameter int IN_W   = 35,
	parameter int SIDE_W = 1,
	localparam int RW    = (IN_W + 1) / 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vld_i,
	input  logic [IN_W-1:0]   x_i,
	input  logic [SIDE_W-1:0] side_i,
	output logic              vld_o,
	output logic [RW-1:0]     root_o,
	output logic [SIDE_W-1:0] side_o
);
	localparam int XW = 2 * RW;

	logic [RW+1:0]     rem_q  [RW];
	logic [RW-1:0]     root_q [RW];
	logic [XW-1:0]     x_q    [RW];
	logic [SIDE_W-1:0] side_q [RW];
	logic              vld_q  [RW];

	for (genvar k = 0; k < RW; k++) begin : g_stage
		logic [RW+1:0]     rem_in;
		logic [RW-1:0]     root_in;
		logic [XW-1:0]     x_in;
		logic [SIDE_W-1:0] side_in;
		logic              vld_in;
		logic [RW+3:0]     t;
		logic [RW+3:0]     trial;

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign x_in    = XW'(x_i);
			assign side_in = side_i;
			assign vld_in  = vld_i;
		end else begin : g_next
			assign rem_in  = rem_q[k-1];
			assign root_in = root_q[k-1];
			assign x_in    = x_q[k-1];
			assign side_in = side_q[k-1];
			assign vld_in  = vld_q[k-1];
		end

		assign t     = {rem_in, x_in[XW-1 -: 2]};
		assign trial = (RW+4)'({root_in, 2'b01});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (en) begin
				vld_q[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (t >= trial) begin
					rem_q[k]  <= (RW+2)'(t - trial);
					root_q[k] <= {root_in[RW-2:0], 1'b1};
				end else begin
					rem_q[k]  <= (RW+2)'(t);
					root_q[k] <= {root_in[RW-2:0], 1'b0};
				end
				x_q[k]    <= x_in << 2;
				side_q[k] <= side_in;
			end
		end
	end

	assign vld_o  = vld_q[RW-1];
	assign root_o = root_q[RW-1];
	assign side_o = side_q[RW-1];
endmodule

// File: hdl/rdcm_div_pipe.sv
// Restoring divider, one quotient bit per stage. rem0_i must be below divisor_i.
module rdcm_div_pipe #(
	parameter int DW     = 18,
	parameter int QW     = 22,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vld_i,
	input  logic [DW-1:0]     rem0_i,
	input  logic [QW-1:0]     low_i,
	input  logic [DW-1:0]     divisor_i,
	input  logic [SIDE_W-1:0] side_i,
	output logic              vld_o,
	output logic [QW-1:0]     quot_o,
	output logic [SIDE_W-1:0] side_o
);
	logic [DW-1:0]     rem_q  [QW];
	logic [QW-1:0]     low_q  [QW];
	logic [QW-1:0]     quot_q [QW];
	logic [SIDE_W-1:0] side_q [QW];
	logic              vld_q  [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [DW-1:0]     rem_in;
		logic [QW-1:0]     low_in;
		logic [QW-1:0]     quot_in;
		logic [SIDE_W-1:0] side_in;
		logic              vld_in;
		logic [DW:0]       t;
		logic [DW:0]       dv;

		if (k == 0) begin : g_first
			assign rem_in  = rem0_i;
			assign low_in  = low_i;
			assign quot_in = '0;
			assign side_in = side_i;
			assign vld_in  = vld_i;
		end else begin : g_next
			assign rem_in  = rem_q[k-1];
			assign low_in  = low_q[k-1];
			assign quot_in = quot_q[k-1];
			assign side_in = side_q[k-1];
			assign vld_in  = vld_q[k-1];
		end

		assign t  = {rem_in, low_in[QW-1]};
		assign dv = {1'b0, divisor_i};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (en) begin
				vld_q[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (t >= dv) begin
					rem_q[k]  <= DW'(t - dv);
					quot_q[k] <= {quot_in[QW-2:0], 1'b1};
				end else begin
					rem_q[k]  <= DW'(t);
					quot_q[k] <= {quot_in[QW-2:0], 1'b0};
				end
				low_q[k]  <= low_in << 1;
				side_q[k] <= side_in;
			end
		end
	end

	assign vld_o  = vld_q[QW-1];
	assign quot_o = quot_q[QW-1];
	assign side_o = side_q[QW-1];
endmodule

// File: hdl/rdcm_table.sv
// Magnification delta table: one write port, two registered read ports.
module rdcm_table import rdcm_pkg::*; #(
	parameter int DEPTH = 64,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic               clk,
	input  logic               en,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  logic [DELTA_W-1:0] wdata,
	input  logic [AW-1:0]      raddr_a,
	input  logic [AW-1:0]      raddr_b,
	output logic [DELTA_W-1:0] rdata_a,
	output logic [DELTA_W-1:0] rdata_b
);
	logic [DELTA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en && we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end
endmodule

// File: hdl/radial_distortion_coordinate_map_unit.sv
// Radial distortion coordinate map.
// item channel: op 1 maps the point (coord_row, coord_col) to its distorted
//   source point; op 0 writes entry_delta into table entry entry_index.
// result channel: one beat per item, in order. Map beats carry src_row,
//   src_col (Q.4), visible and mapped = 1; load beats are all zero.
// Config port: cfg_we/cfg_index/cfg_data; the user must see that it is written
//   only while no item is in flight, the block itself does not enforce it.
//   The edge radius is rebuilt from the registers by its own root pipeline
//   that runs every cycle; it settles by the time an item accepted right
//   behind the write reaches the edge compare.
// Pipeline: local stages s1 to s11 around the bit-per-stage square root
//   (RW = root bits, 18) and the bit-per-stage divider (QW = quotient bits,
//   clog2(TABLE_DEPTH)+16, 22), figures at default parameters.
// Throughput: one beat per cycle while the result channel is not stalled.
// Stall: the whole pipeline advances together; when the result beat is held
//   the pipeline freezes and item.ready drops, nothing is lost or repeated.
// Reset: clears valid bits and restores register defaults; table entries
//   are undefined until loaded.
module radial_distortion_coordinate_map_unit import rdcm_pkg::*; #(
	parameter int TABLE_DEPTH = 64,
	parameter int MAX_DIM     = 4096,
	parameter int FRAC_BITS   = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	rdcm_in_if.sink              item,
	rdcm_out_if.source           result
);
	// derived widths
	localparam int HW    = $clog2(MAX_DIM + 1);          // clamped dimension
	localparam int HFW   = HW + FRAC_BITS;               // dimension in Q.FRAC
	localparam int DW    = (HFW > COORD_W) ? HFW : COORD_W;
	localparam int SUM_W = 2 * DW + 1;
	localparam int RW    = (SUM_W + 1) / 2;              // radius width
	localparam int IW    = $clog2(TABLE_DEPTH);          // table index width
	localparam int NW    = $clog2(TABLE_DEPTH + 1);      // entries in use
	localparam int QW    = IW + PFRAC_W;                 // table position
	localparam int PW    = RW + IW;
	localparam int NEG_LIM = -(2 ** FRAC_BITS);

	// ---------------- configuration ----------------
	logic [COORD_W-1:0] center_row_q, center_col_q;
	logic [DIM_W-1:0]   image_height_q, image_width_q;
	logic [CNT_W-1:0]   table_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_row_q   <= '0;
			center_col_q   <= '0;
			image_height_q <= DIM_W'(4096);
			image_width_q  <= DIM_W'(4096);
			table_count_q  <= CNT_W'(64);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CENTER_ROW:   center_row_q   <= cfg_data;
				CFG_CENTER_COL:   center_col_q   <= cfg_data;
				CFG_IMAGE_HEIGHT: image_height_q <= cfg_data[DIM_W-1:0];
				CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data[DIM_W-1:0];
				CFG_TABLE_COUNT:  table_count_q  <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// clamped sizes and entry count, to be kept static while items are in flight (not enforced here)
	logic [HW-1:0]  hgt_c, wid_c;
	logic [HFW-1:0] hgt_f, wid_f;
	logic [NW-1:0]  n_use;
	logic [IW-1:0]  n_m1;

	assign hgt_c = (32'(image_height_q) > MAX_DIM) ? HW'(MAX_DIM) : HW'(image_height_q);
	assign wid_c = (32'(image_width_q) > MAX_DIM) ? HW'(MAX_DIM) : HW'(image_width_q);
	assign hgt_f = HFW'(hgt_c) << FRAC_BITS;
	assign wid_f = HFW'(wid_c) << FRAC_BITS;
	assign n_use = (table_count_q == '0) ? NW'(1) :
		(32'(table_count_q) > TABLE_DEPTH) ? NW'(TABLE_DEPTH) : NW'(table_count_q);
	assign n_m1  = IW'(n_use - NW'(1));

	// ---------------- edge radius ----------------
	// farthest corner distance per axis: max(dim - c, c)
	logic [DW:0]        hgt_x, wid_x, crow_x, ccol_x;
	logic [DW-1:0]      edge_dr_q, edge_dc_q;
	logic [2*DW-1:0]    edge_sqr_q, edge_sqc_q;
	logic [SUM_W-1:0]   edge_sum_q;
	logic [RW-1:0]      edge_radius;

	assign hgt_x  = (DW+1)'(hgt_f);
	assign wid_x  = (DW+1)'(wid_f);
	assign crow_x = (DW+1)'(center_row_q);
	assign ccol_x = (DW+1)'(center_col_q);

	always_ff @(posedge clk) begin
		edge_dr_q  <= (hgt_x > (crow_x << 1)) ? DW'(hgt_x - crow_x) : DW'(crow_x);
		edge_dc_q  <= (wid_x > (ccol_x << 1)) ? DW'(wid_x - ccol_x) : DW'(ccol_x);
		edge_sqr_q <= (2*DW)'(edge_dr_q) * (2*DW)'(edge_dr_q);
		edge_sqc_q <= (2*DW)'(edge_dc_q) * (2*DW)'(edge_dc_q);
		edge_sum_q <= SUM_W'(edge_sqr_q) + SUM_W'(edge_sqc_q);
	end

	rdcm_isqrt_pipe #(.IN_W(SUM_W), .SIDE_W(1)) u_edge_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (1'b1),
		.vld_i  (1'b1),
		.x_i    (edge_sum_q),
		.side_i (1'b0),
		.vld_o  (),
		.root_o (edge_radius),
		.side_o ()
	);

	// ---------------- item pipeline ----------------
	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;

	assign adv        = !v_s11 || result.ready;
	assign item.ready = adv;

	// s1: offsets from center as sign and magnitude
	item_side_t side_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1.op    <= item.op;
			side_s1.idx   <= item.entry_index;
			side_s1.delta <= item.entry_delta;
			side_s1.row_neg <= item.coord_row < center_row_q;
			side_s1.row_mag <= (item.coord_row < center_row_q) ?
				center_row_q - item.coord_row : item.coord_row - center_row_q;
			side_s1.col_neg <= item.coord_col < center_col_q;
			side_s1.col_mag <= (item.coord_col < center_col_q) ?
				center_col_q - item.coord_col : item.coord_col - center_col_q;
		end
	end

	// s2: squares
	item_side_t           side_s2;
	logic [2*COORD_W-1:0] sqr_s2, sqc_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2 <= side_s1;
			sqr_s2  <= (2*COORD_W)'(side_s1.row_mag) * (2*COORD_W)'(side_s1.row_mag);
			sqc_s2  <= (2*COORD_W)'(side_s1.col_mag) * (2*COORD_W)'(side_s1.col_mag);
		end
	end

	// s3: squared radius
	item_side_t       side_s3;
	logic [SUM_W-1:0] sum_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s3 <= side_s2;
			sum_s3  <= SUM_W'(sqr_s2) + SUM_W'(sqc_s2);
		end
	end

	// radius
	logic          v_rt;
	logic [RW-1:0] radius;
	item_side_t    side_rt;

	rdcm_isqrt_pipe #(.IN_W(SUM_W), .SIDE_W($bits(item_side_t))) u_item_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.vld_i  (v_s3),
		.x_i    (sum_s3),
		.side_i (side_s3),
		.vld_o  (v_rt),
		.root_o (radius),
		.side_o (side_rt)
	);

	// s4: radius*(n-1), split into divider start remainder and low bits
	logic          in_edge;
	logic [PW-1:0] scaled;
	logic [RW-1:0] rem0_s4;
	logic [QW-1:0] low_s4;
	div_side_t     side_s4;

	assign in_edge = radius < edge_radius;
	assign scaled  = in_edge ? PW'(radius) * PW'(n_m1) : '0;

	always_ff @(posedge clk) begin
		if (adv) begin
			rem0_s4         <= scaled[PW-1:IW];
			low_s4          <= {scaled[IW-1:0], PFRAC_W'(0)};
			side_s4.it      <= side_rt;
			side_s4.in_edge <= in_edge;
		end
	end

	// table position = radius*(n-1)*2^16 / edge radius
	logic          v_dv;
	logic [QW-1:0] tpos;
	div_side_t     side_dv;

	rdcm_div_pipe #(.DW(RW), .QW(QW), .SIDE_W($bits(div_side_t))) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.vld_i     (v_s4),
		.rem0_i    (rem0_s4),
		.low_i     (low_s4),
		.divisor_i (edge_radius),
		.side_i    (side_s4),
		.vld_o     (v_dv),
		.quot_o    (tpos),
		.side_o    (side_dv)
	);

	// s5: entry pair and weight; outside the edge both entries are the last
	logic [IW-1:0]      pos_i;
	logic [IW:0]        pos_ip1;
	logic [IW-1:0]      idx_a_s5, idx_b_s5;
	logic [PFRAC_W-1:0] frac_s5;
	item_side_t         side_s5;

	assign pos_i   = tpos[QW-1:PFRAC_W];
	assign pos_ip1 = (IW+1)'(pos_i) + (IW+1)'(1);

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s5 <= side_dv.it;
			if (side_dv.in_edge) begin
				idx_a_s5 <= pos_i;
				idx_b_s5 <= (pos_ip1 < (IW+1)'(n_use)) ? IW'(pos_ip1) : n_m1;
				frac_s5  <= tpos[PFRAC_W-1:0];
			end else begin
				idx_a_s5 <= n_m1;
				idx_b_s5 <= n_m1;
				frac_s5  <= '0;
			end
		end
	end

	// table write happens at the read stage, so loads and reads stay in order
	logic               tbl_we;
	logic [DELTA_W-1:0] delta_a_s6, delta_b_s6;

	assign tbl_we = v_s5 && (side_s5.op == OP_LOAD) && (32'(side_s5.idx) < TABLE_DEPTH);

	rdcm_table #(.DEPTH(TABLE_DEPTH)) u_table (
		.clk     (clk),
		.en      (adv),
		.we      (tbl_we),
		.waddr   (IW'(side_s5.idx)),
		.wdata   (side_s5.delta),
		.raddr_a (idx_a_s5),
		.raddr_b (idx_b_s5),
		.rdata_a (delta_a_s6),
		.rdata_b (delta_b_s6)
	);

	// s6: table data lands
	logic [PFRAC_W-1:0] frac_s6;
	item_side_t         side_s6;
	always_ff @(posedge clk) begin
		if (adv) begin
			frac_s6 <= frac_s5;
			side_s6 <= side_s5;
		end
	end

	// s7: weighted factors, Q1.15 factor = delta + 1.0
	localparam int WP_W = PFRAC_W + 1 + FACT_W;
	logic [WP_W-1:0] wprod_a_s7, wprod_b_s7;
	item_side_t      side_s7;
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s7    <= side_s6;
			wprod_a_s7 <= WP_W'((PFRAC_W+1)'(1 << PFRAC_W) - (PFRAC_W+1)'(frac_s6)) *
				WP_W'(delta_a_s6 ^ ONE_Q15);
			wprod_b_s7 <= WP_W'(frac_s6) * WP_W'(delta_b_s6 ^ ONE_Q15);
		end
	end

	// s8: magnification in Q.31
	logic [MAG_W-1:0] mag_s8;
	item_side_t       side_s8;
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s8 <= side_s7;
			mag_s8  <= MAG_W'(wprod_a_s7 + wprod_b_s7);
		end
	end

	// s9: scaled offset magnitudes
	localparam int SP_W = COORD_W + MAG_W;
	logic [SP_W-1:0] sprod_r_s9, sprod_c_s9;
	item_side_t      side_s9;
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s9    <= side_s8;
			sprod_r_s9 <= SP_W'(side_s8.row_mag) * SP_W'(mag_s8);
			sprod_c_s9 <= SP_W'(side_s8.col_mag) * SP_W'(mag_s8);
		end
	end

	// s10: sign back on, add center
	logic [SP_W-SCALE_SH-1:0] soff_r, soff_c;
	logic [OUT_W-1:0]         srow_s10, scol_s10;
	logic                     map_s10;

	assign soff_r = sprod_r_s9[SP_W-1:SCALE_SH];
	assign soff_c = sprod_c_s9[SP_W-1:SCALE_SH];

	always_ff @(posedge clk) begin
		if (adv) begin
			map_s10 <= side_s9.op == OP_MAP;
			if (side_s9.op == OP_MAP) begin
				srow_s10 <= side_s9.row_neg ? OUT_W'(center_row_q) - OUT_W'(soff_r) :
					OUT_W'(center_row_q) + OUT_W'(soff_r);
				scol_s10 <= side_s9.col_neg ? OUT_W'(center_col_q) - OUT_W'(soff_c) :
					OUT_W'(center_col_q) + OUT_W'(soff_c);
			end else begin
				srow_s10 <= '0;
				scol_s10 <= '0;
			end
		end
	end

	// s11: output register and visibility. Truncation toward zero puts
	// sources just below zero on pixel 0.
	int  srow_i, scol_i, srow_clip, scol_clip;
	logic vis;

	assign srow_i    = int'($signed(srow_s10));
	assign scol_i    = int'($signed(scol_s10));
	assign srow_clip = (srow_i < 0) ? 0 : srow_i;
	assign scol_clip = (scol_i < 0) ? 0 : scol_i;
	assign vis = map_s10 && (srow_i > NEG_LIM) && (scol_i > NEG_LIM) &&
		(srow_clip < int'(hgt_f)) && (scol_clip < int'(wid_f));

	always_ff @(posedge clk) begin
		if (adv) begin
			result.src_row <= srow_s10;
			result.src_col <= scol_s10;
			result.visible <= vis;
			result.mapped  <= map_s10;
		end
	end

	assign result.valid = v_s11;

	// valid bits of the local stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else if (adv) begin
			v_s1  <= item.valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_rt;
			v_s5  <= v_dv;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
		end
	end

`ifndef NO_ASSERTIONS
	// an accepted beat always enters the first stage
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready) |=> v_s1)
		else $error("accepted item lost at pipeline entry");

	// load beats carry no coordinates
	a_load_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.mapped) |->
		(result.src_row == '0 && result.src_col == '0 && !result.visible))
		else $error("load result carries payload");

	// a held result freezes the pipeline front
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s11 && !result.ready) |-> !item.ready)
		else $error("item taken while result stalled");
`endif
endmodule
